// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes of the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned POLL_W    = 8;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 16;

    // command kinds, also the engine state
    localparam logic [2:0] KIND_IDLE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // sequence step codes; the ack steps follow the data bits
    localparam logic [STEP_W-1:0] STEP_ACK     = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ACK_CLK = 5'd17;
    localparam logic [STEP_W-1:0] STEP_ONE     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_THREE   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_BIT = 5'd15;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL    = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd2;
    localparam logic [POLL_W-1:0]  ACK_POLL_RST    = 8'd255;

    // classified tick word between front and back
    typedef struct packed {
        logic       sda;
        logic       ack;
        logic [7:0] tx;
        logic [2:0] kind;
    } t_cmd_word;

    // result word
    typedef struct packed {
        logic       ack_ok;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_res_word;

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master bit engine, one input word per bus timing tick
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (lsb up)                              tuser
// s_axis    in   req_type[2:0] tx_byte[10:3] ack_after_read[11]     -
//                sda_in[12]
// m_axis    out  scl_out[0] sda_out[1] busy_res[2] done_res[3]      -
//                rx_byte[11:4] ack_ok[12]
// cfg       in   idx 0 phase_ticks, idx 1 ack_poll_limit            -
//
// one word per cycle while neither side stalls; each word passes the two-entry
// front queue and the sequencer, and the result is registered
// the sequencer updates all bus state once per word
// synchronous active-low reset; pins reset released, engine idle
// either side may stall; the queue and the result register absorb it
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // req_type, tx_byte, ack_after_read, sda_in, zero pad
    input  logic [i2cm_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // scl_out, sda_out, busy_res, done_res, rx_byte, ack_ok, zero pad
    output logic [i2cm_pkg::OUT_W-1:0]         o_m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0]         i_cfg_data
);

    logic                w_head_valid;
    i2cm_pkg::t_cmd_word w_head;
    logic                w_pop;
    i2cm_pkg::t_res_word w_res;

    i2cm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .o_in_ready       (o_s_axis_tready),
        .i_req_type       (i_s_axis_tdata[2:0]),
        .i_tx_byte        (i_s_axis_tdata[10:3]),
        .i_ack_after_read (i_s_axis_tdata[11]),
        .i_sda_in         (i_s_axis_tdata[12]),
        .o_head_valid     (w_head_valid),
        .o_head           (w_head),
        .i_pop            (w_pop)
    );

    i2cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_res_valid  (o_m_axis_tvalid),
        .o_res        (w_res),
        .i_res_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {3'b000, w_res};

endmodule

// ===== rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// accepts input words, classifies the request and queues them two deep
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_ack_after_read,
    input  logic                i_sda_in,
    output logic                o_head_valid,
    output i2cm_pkg::t_cmd_word o_head,
    input  logic                i_pop
);

    i2cm_pkg::t_cmd_word r_mem [2];
    logic                r_wr_ptr, n_wr_ptr;
    logic                r_rd_ptr, n_rd_ptr;
    logic [1:0]          r_count, n_count;
    i2cm_pkg::t_cmd_word w_word;
    logic                w_push;
    logic                w_pop;

    // anything outside start..read is a plain tick
    always_comb begin
        w_word.sda = i_sda_in;
        w_word.ack = i_ack_after_read;
        w_word.tx  = i_tx_byte;
        case (i_req_type) inside
            [i2cm_pkg::KIND_START:i2cm_pkg::KIND_READ]: w_word.kind = i_req_type;
            default: w_word.kind = i2cm_pkg::KIND_IDLE;
        endcase
    end

    assign o_in_ready   = (r_count != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

endmodule

// ===== rtl/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// bus phase sequencer, config registers and result register
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_head_valid,
    input  i2cm_pkg::t_cmd_word                   i_head,
    output logic                                  o_pop,
    output logic                                  o_res_valid,
    output i2cm_pkg::t_res_word                   o_res,
    input  logic                                  i_res_ready
);

    logic [i2cm_pkg::PHASE_W-1:0] r_phase_ticks;
    logic [i2cm_pkg::POLL_W-1:0]  r_ack_poll;

    logic [2:0]                   r_kind, n_kind;
    logic [i2cm_pkg::STEP_W-1:0]  r_step, n_step;
    logic [i2cm_pkg::PHASE_W-1:0] r_phase_cnt, n_phase_cnt;
    logic [7:0]                   r_shift, n_shift;
    logic [i2cm_pkg::POLL_W-1:0]  r_poll, n_poll;
    logic                         r_send_ack, n_send_ack;
    logic                         r_scl, n_scl;
    logic                         r_sda, n_sda;
    logic [7:0]                   r_rx, n_rx;
    logic                         r_acked, n_acked;
    logic                         n_done;
    logic [i2cm_pkg::PHASE_W-1:0] w_limit;
    logic                         w_fire;
    logic                         r_res_valid;
    i2cm_pkg::t_res_word          r_res;

    // pin levels on entry to a phase, returns {scl, sda}
    function automatic logic [1:0] f_enter(input logic [2:0] kind,
                                           input logic [i2cm_pkg::STEP_W-1:0] s,
                                           input logic msb, input logic sack,
                                           input logic scl, input logic sda);
        logic [1:0] v;
        v = {scl, sda};
        case (kind)
            i2cm_pkg::KIND_START: begin
                if (s == '0) v = 2'b11;
                else v = {scl, 1'b0};
            end
            i2cm_pkg::KIND_STOP: begin
                if (s == '0) v = 2'b00;
                else if (s == i2cm_pkg::STEP_ONE) v = {1'b1, sda};
                else if (s == 5'd2) v = {scl, 1'b1};
                else v = {1'b0, sda};
            end
            i2cm_pkg::KIND_WRITE: begin
                if (!s[4]) v = s[0] ? {1'b1, sda} : {1'b0, msb};
                else if (s == i2cm_pkg::STEP_ACK) v = 2'b01;
                else if (s == i2cm_pkg::STEP_ACK_CLK) v = {1'b1, sda};
                else v = {1'b0, sda};
            end
            i2cm_pkg::KIND_READ: begin
                if (!s[4]) v = s[0] ? {1'b1, sda} : 2'b01;
                else if (s == i2cm_pkg::STEP_ACK) v = {1'b0, ~sack};
                else v = {1'b1, sda};
            end
            default: v = {scl, sda};
        endcase
        return v;
    endfunction

    assign w_limit = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
    assign w_fire  = i_head_valid && (!r_res_valid || i_res_ready);
    assign o_pop   = w_fire;

    always_comb begin
        n_kind      = r_kind;
        n_step      = r_step;
        n_phase_cnt = r_phase_cnt;
        n_shift     = r_shift;
        n_poll      = r_poll;
        n_send_ack  = r_send_ack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_rx        = r_rx;
        n_acked     = r_acked;
        n_done      = 1'b0;

        if (r_kind == i2cm_pkg::KIND_IDLE && i_head.kind != i2cm_pkg::KIND_IDLE) begin
            n_kind      = i_head.kind;
            n_step      = '0;
            n_phase_cnt = '0;
            n_shift     = (i_head.kind == i2cm_pkg::KIND_WRITE) ? i_head.tx : 8'd0;
            n_send_ack  = i_head.ack;
            n_poll      = r_ack_poll;
            {n_scl, n_sda} = f_enter(n_kind, n_step, n_shift[7], n_send_ack, n_scl, n_sda);
        end

        if (n_kind != i2cm_pkg::KIND_IDLE) begin
            n_phase_cnt = n_phase_cnt + 16'd1;
            if (n_phase_cnt >= w_limit || n_phase_cnt == '0) begin
                n_phase_cnt = '0;
                case (n_kind)
                    i2cm_pkg::KIND_START: begin
                        if (n_step >= i2cm_pkg::STEP_ONE) begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end else begin
                            n_step = n_step + 5'd1;
                        end
                    end
                    i2cm_pkg::KIND_STOP: begin
                        if (n_step >= i2cm_pkg::STEP_THREE) n_done = 1'b1;
                        else n_step = n_step + 5'd1;
                    end
                    i2cm_pkg::KIND_WRITE: begin
                        if (!n_step[4]) begin
                            if (n_step[0]) n_shift = {n_shift[6:0], 1'b0};
                            if (n_step == i2cm_pkg::STEP_LAST_BIT && n_poll == '0) begin
                                n_scl   = 1'b0;
                                n_sda   = 1'b1;
                                n_acked = 1'b0;
                                n_done  = 1'b1;
                            end else begin
                                n_step = n_step + 5'd1;
                            end
                        end else if (n_step == i2cm_pkg::STEP_ACK) begin
                            if (!i_head.sda) begin
                                n_step = n_step + 5'd1;
                            end else begin
                                n_poll = n_poll - 8'd1;
                                if (n_poll == '0) begin
                                    n_acked = 1'b0;
                                    n_done  = 1'b1;
                                end
                            end
                        end else if (n_step == i2cm_pkg::STEP_ACK_CLK) begin
                            n_step = n_step + 5'd1;
                        end else begin
                            n_acked = 1'b1;
                            n_done  = 1'b1;
                        end
                    end
                    i2cm_pkg::KIND_READ: begin
                        if (!n_step[4]) begin
                            if (n_step[0]) n_shift = {n_shift[6:0], i_head.sda};
                            n_step = n_step + 5'd1;
                        end else if (n_step == i2cm_pkg::STEP_ACK) begin
                            n_step = n_step + 5'd1;
                        end else begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                    default: n_done = 1'b1;
                endcase

                if (n_done) begin
                    if (n_kind == i2cm_pkg::KIND_READ) n_rx = n_shift;
                    n_kind      = i2cm_pkg::KIND_IDLE;
                    n_step      = '0;
                    n_phase_cnt = '0;
                end else begin
                    {n_scl, n_sda} = f_enter(n_kind, n_step, n_shift[7], n_send_ack,
                                             n_scl, n_sda);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
            r_ack_poll    <= i2cm_pkg::ACK_POLL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cm_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                i2cm_pkg::CFG_ACK_POLL:    r_ack_poll    <= i_cfg_data[i2cm_pkg::POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= i2cm_pkg::KIND_IDLE;
            r_step      <= '0;
            r_phase_cnt <= '0;
            r_shift     <= '0;
            r_poll      <= '0;
            r_send_ack  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= '0;
            r_acked     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_kind      <= n_kind;
                r_step      <= n_step;
                r_phase_cnt <= n_phase_cnt;
                r_shift     <= n_shift;
                r_poll      <= n_poll;
                r_send_ack  <= n_send_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_rx        <= n_rx;
                r_acked     <= n_acked;
            end
            if (w_fire) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.scl_out  <= n_scl;
            r_res.sda_out  <= n_sda;
            r_res.busy_res <= (n_kind != i2cm_pkg::KIND_IDLE);
            r_res.done_res <= n_done;
            r_res.rx_byte  <= n_rx;
            r_res.ack_ok   <= n_acked;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
